### rtl/ssvt_pkg.sv
// Shared types and constants for the subset-sum valuation table.
package ssvt_pkg;

   // Fixed field widths
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 3;
   localparam int VAL_W    = 16;
   localparam int MASK_W   = 8;
   localparam int ENTRY_W  = 20;
   localparam int NORM_W   = 16;
   localparam int NUM_W    = 4;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 2;

   // Normalize datapath: product width and divider step counter
   localparam int PROD_W = ENTRY_W + NORM_W;
   localparam int STEP_W = 6;

   localparam logic [ENTRY_W-1:0] ENTRY_MAX = 20'hFFFFF;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ITEMS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_VALUE = 2'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE  = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_NORM   = 2'd2,
      CMD_LOOKUP = 2'd3
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_UNBUILT  = 2'd2,
      ST_ZERO_SUM = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_BLD_ZERO,
      S_BLD_RD,
      S_BLD_WR,
      S_NRM_TOT,
      S_NRM_CHK,
      S_NRM_RD,
      S_NRM_MUL,
      S_NRM_DIV,
      S_NRM_WR,
      S_FINISH
   } state_type;

endpackage

### rtl/subset_sum_valuation_table.sv
// Subset-sum valuation table: item values, subset table memory and command sequencer.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------------------
//  req     | in        | req_tvalid / req_tready | tuser: command; tdata: index,value,mask
//  rsp     | out       | rsp_tvalid / rsp_tready | tuser: status; tdata: bundle_value
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// Write item and lookup go straight from idle to the finish state (lookup: one registered
// table read). Build, for n active items, uses one table read and one shared adder per
// entry. Normalize uses a 36-step restoring divider, shared by every entry.
// Reset clears item values, the built flag and the control registers; the table is not cleared.
// req_tready is high only while the sequencer is idle; a result stalled on rsp
// holds the sequencer in its finish state.
module subset_sum_valuation_table
   import ssvt_pkg::*;
#(
   parameter int MAX_ITEMS  = 8,
   parameter int VALUE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request stream
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // item_index[2:0], item_value[18:3], bundle_mask[26:19]
   input  logic [CMD_W-1:0]     req_tuser,   // command[1:0]
   // response stream
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [23:0]          rsp_tdata,   // bundle_value[19:0]
   output logic [STAT_W-1:0]    rsp_tuser,   // status[1:0]
   // configuration writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [NORM_W-1:0]    csr_data
);

   localparam int AW    = MAX_ITEMS;
   localparam int MW1   = MAX_ITEMS + 1;
   localparam int DEPTH = 1 << MAX_ITEMS;
   localparam int IW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_W = ((VALUE_BITS > ENTRY_W) ? VALUE_BITS : ENTRY_W) + 1;
   localparam logic [NUM_W-1:0]  MAX_N     = NUM_W'(MAX_ITEMS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

   // Request fields
   command_type           req_cmd;
   logic [IDX_W-1:0]      req_index;
   logic [VAL_W-1:0]      req_value;
   logic [MASK_W-1:0]     req_mask;
   logic                  req_xfer;

   // Control registers
   state_type             state_ff, state_in;
   logic [MW1-1:0]        mask_ff, mask_in;
   logic [IW-1:0]         top_ff, top_in;
   logic                  built_ff, built_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [NUM_W-1:0]      num_items_ff, num_items_in;
   logic [NORM_W-1:0]     normal_ff, normal_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [ENTRY_W-1:0]    total_ff, total_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [ENTRY_W-1:0]    rem_ff, rem_in;
   status_type            status_ff, status_in;
   logic                  lookup_ok_ff, lookup_ok_in;
   logic [ENTRY_W-1:0]    rsp_value_ff, rsp_value_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] item_values_ff [MAX_ITEMS];

   // Table memory
   logic [ENTRY_W-1:0]    table_mem [DEPTH];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0]    mem_wdata;

   // Derived values
   logic [NUM_W-1:0]      active;
   logic [MW1-1:0]        span;
   logic [MW1-1:0]        top_bit;
   logic [MW1-1:0]        mask_next;
   logic [SUM_W-1:0]      build_sum;
   logic [ENTRY_W-1:0]    build_entry;
   logic [PROD_W-1:0]     mul_res;
   logic [ENTRY_W:0]      div_shift;
   logic                  div_ge;
   logic [ENTRY_W-1:0]    norm_entry;
   logic                  mask_out_of_range;
   logic                  rsp_free;

   assign req_cmd   = command_type'(req_tuser);
   assign req_index = req_tdata[2:0];
   assign req_value = req_tdata[18:3];
   assign req_mask  = req_tdata[26:19];

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // Clamped item count and table span
   always_comb begin
      if (num_items_ff == '0) begin
         active = NUM_W'(1);
      end else if (num_items_ff > MAX_N) begin
         active = MAX_N;
      end else begin
         active = num_items_ff;
      end
   end
   assign span      = MW1'(1) << active;
   assign top_bit   = MW1'(1) << top_ff;
   assign mask_next = mask_ff + MW1'(1);

   assign mask_out_of_range = (32'(req_mask) >= 32'(span));

   // Shared adder for build: entry(mask) = entry(mask without top bit) + value(top)
   assign build_sum   = SUM_W'(rd_data_ff) + SUM_W'(item_values_ff[top_ff]);
   assign build_entry = (build_sum > SUM_W'(ENTRY_MAX)) ? ENTRY_MAX : build_sum[ENTRY_W-1:0];

   // Normalize: one multiply, then a restoring divider one quotient bit per cycle
   assign mul_res    = PROD_W'(rd_data_ff) * PROD_W'(normal_ff);
   assign div_shift  = {rem_ff, prod_ff[PROD_W-1]};
   assign div_ge     = (div_shift >= {1'b0, total_ff});
   assign norm_entry = (|prod_ff[PROD_W-1:ENTRY_W]) ? ENTRY_MAX : prod_ff[ENTRY_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_cmd)
                  CMD_BUILD: state_in = S_BLD_ZERO;
                  CMD_NORM: begin
                     if (normal_ff == '0 || !built_ff) begin
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_NRM_TOT;
                     end
                  end
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_BLD_ZERO: state_in = S_BLD_RD;
         S_BLD_RD:   state_in = S_BLD_WR;
         S_BLD_WR: begin
            state_in = (mask_next == span) ? S_FINISH : S_BLD_RD;
         end
         S_NRM_TOT: state_in = S_NRM_CHK;
         S_NRM_CHK: state_in = (rd_data_ff == '0) ? S_FINISH : S_NRM_RD;
         S_NRM_RD:  state_in = S_NRM_MUL;
         S_NRM_MUL: state_in = S_NRM_DIV;
         S_NRM_DIV: state_in = (step_ff == LAST_STEP) ? S_NRM_WR : S_NRM_DIV;
         S_NRM_WR: begin
            state_in = (mask_next == span) ? S_FINISH : S_NRM_RD;
         end
         S_FINISH: state_in = rsp_free ? S_IDLE : S_FINISH;
         default:  state_in = S_IDLE;
      endcase
   end

   // Memory port control
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = mask_ff[AW-1:0];
      mem_wdata = build_entry;
      mem_re    = 1'b0;
      mem_raddr = mask_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(req_mask);
         end
         S_BLD_ZERO: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '0;
         end
         S_BLD_RD: begin
            mem_re    = 1'b1;
            mem_raddr = mask_ff[AW-1:0] & ~top_bit[AW-1:0];
         end
         S_BLD_WR: mem_we = 1'b1;
         S_NRM_TOT: begin
            mem_re    = 1'b1;
            mem_raddr = span[AW-1:0] - AW'(1);
         end
         S_NRM_RD: mem_re = 1'b1;
         S_NRM_WR: begin
            mem_we    = 1'b1;
            mem_wdata = norm_entry;
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      mask_in       = mask_ff;
      top_in        = top_ff;
      built_in      = built_ff;
      step_in       = step_ff;
      num_items_in  = num_items_ff;
      normal_in     = normal_ff;
      total_in      = total_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      status_in     = status_ff;
      lookup_ok_in  = lookup_ok_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               status_in    = ST_OK;
               lookup_ok_in = 1'b0;
               case (req_cmd)
                  CMD_NORM: begin
                     if (normal_ff != '0 && !built_ff) begin
                        status_in = ST_UNBUILT;
                     end
                  end
                  CMD_LOOKUP: begin
                     if (!built_ff) begin
                        status_in = ST_UNBUILT;
                     end else if (mask_out_of_range) begin
                        status_in = ST_RANGE;
                     end else begin
                        lookup_ok_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_BLD_ZERO: begin
            mask_in = MW1'(1);
            top_in  = '0;
         end
         S_BLD_WR: begin
            mask_in = mask_next;
            if (mask_next == span) begin
               built_in = 1'b1;
            end else if (mask_next == (top_bit << 1)) begin
               top_in = top_ff + IW'(1);
            end
         end
         S_NRM_CHK: begin
            total_in = rd_data_ff;
            mask_in  = '0;
            if (rd_data_ff == '0) begin
               status_in = ST_ZERO_SUM;
            end
         end
         S_NRM_MUL: begin
            prod_in = mul_res;
            rem_in  = '0;
            step_in = '0;
         end
         S_NRM_DIV: begin
            rem_in  = div_ge ? ENTRY_W'(div_shift - {1'b0, total_ff}) : div_shift[ENTRY_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
         end
         S_NRM_WR: mask_in = mask_next;
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = lookup_ok_ff ? rd_data_ff : '0;
               rsp_status_in = status_ff;
            end
         end
         default: ;
      endcase
      // configuration writes; a new item count invalidates the table
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_NUM_ITEMS) begin
            num_items_in = csr_data[NUM_W-1:0];
            built_in     = 1'b0;
         end else if (csr_index == CSR_NORMAL_VALUE) begin
            normal_in = csr_data;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mask_ff      <= '0;
         top_ff       <= '0;
         built_ff     <= 1'b0;
         step_ff      <= '0;
         num_items_ff <= NUM_W'(8);
         normal_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         top_ff       <= top_in;
         built_ff     <= built_in;
         step_ff      <= step_in;
         num_items_ff <= num_items_in;
         normal_ff    <= normal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      total_ff      <= total_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      status_ff     <= status_in;
      lookup_ok_ff  <= lookup_ok_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Item values; writes at an index of MAX_ITEMS or above are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ITEMS; i++) begin
            item_values_ff[i] <= '0;
         end
      end else if (req_xfer && req_cmd == CMD_WRITE && 32'(req_index) < MAX_ITEMS) begin
         item_values_ff[IW'(req_index)] <= VALUE_BITS'(req_value);
      end
   end

   // Subset table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= table_mem[mem_raddr];
      end
   end

   // Checks
   a_err_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_value_ff == '0))
      else $error("nonzero bundle_value with error status");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_FINISH) |-> !mem_we)
      else $error("table write outside a walk");

   a_lookup_built: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && lookup_ok_ff) |-> built_ff)
      else $error("lookup hit on unbuilt table");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NRM_DIV) |-> (rem_ff < total_ff))
      else $error("divider remainder not below divisor");

   a_build_sets_flag: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == S_BLD_WR) && state_ff == S_FINISH) |-> built_ff)
      else $error("build finished without setting built flag");

endmodule

### tb/subset_sum_valuation_table_tb.sv
// Self-checking testbench for the subset-sum valuation table: streamed commands vs. a local model.
`timescale 1ns / 1ps

module subset_sum_valuation_table_tb;
   import ssvt_pkg::*;

   localparam int ITEM_SLOTS  = 8;
   localparam int TABLE_SLOTS = 256;
   localparam int ITEM_TARGET = 1750;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      command_type      cmd;
      logic [IDX_W-1:0]  idx;
      logic [VAL_W-1:0]  value;
      logic [MASK_W-1:0] mask;
   } ssvt_req_type;

   typedef struct {
      logic [ENTRY_W-1:0] value;
      status_type         status;
   } ssvt_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [31:0]          req_tdata  = '0;
   logic [CMD_W-1:0]     req_tuser  = CMD_WRITE;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;
   logic [STAT_W-1:0]    rsp_tuser;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = CSR_NUM_ITEMS;
   logic [NORM_W-1:0]    csr_data   = '0;

   // Local copy of block state and registers
   logic [VAL_W-1:0]   item_vals [ITEM_SLOTS];
   logic [ENTRY_W-1:0] sums      [TABLE_SLOTS];
   logic               sums_ready = 1'b0;
   logic [NUM_W-1:0]   cfg_count  = 4'd8;
   logic [NORM_W-1:0]  cfg_target = '0;

   ssvt_req_type pending_reqs  [$];
   ssvt_rsp_type expected_rsps [$];

   int  error_count  = 0;
   int  queued_total = 0;
   int  phase_no     = 0;
   int  cycle_count  = 0;
   int  burst_left   = 4;
   int  gap_left     = 0;
   int  rx_mode      = 0;
   int  rx_left      = 0;
   logic rsp_hold    = 1'b0;

   subset_sum_valuation_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < ITEM_SLOTS; i++) item_vals[i] = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) sums[i] = '0;
   end

   // Item count after clamping to 1..ITEM_SLOTS
   function automatic int active_items();
      if (cfg_count < 1) return 1;
      if (cfg_count > ITEM_SLOTS) return ITEM_SLOTS;
      return int'(cfg_count);
   endfunction

   // Apply one command to the local state, return the result it yields
   function automatic ssvt_rsp_type predict_response(ssvt_req_type r);
      ssvt_rsp_type     o;
      int               n;
      int               span;
      int               m;
      int               b;
      longint unsigned  acc;
      longint unsigned  total;
      o.value  = '0;
      o.status = ST_OK;
      n        = active_items();
      span     = 1 << n;
      case (r.cmd)
         CMD_WRITE: begin
            if (r.idx < ITEM_SLOTS) item_vals[r.idx] = r.value;
         end
         CMD_BUILD: begin
            for (m = 0; m < span; m++) begin
               acc = 0;
               for (b = 0; b < n; b++)
                  if (((m >> b) & 1) != 0) acc += item_vals[b];
               sums[m] = (acc > ENTRY_MAX) ? ENTRY_MAX : acc[ENTRY_W-1:0];
            end
            sums_ready = 1'b1;
         end
         CMD_NORM: begin
            if (cfg_target != 0) begin
               if (!sums_ready) o.status = ST_UNBUILT;
               else begin
                  total = sums[span-1];
                  if (total == 0) o.status = ST_ZERO_SUM;
                  else begin
                     for (m = 0; m < span; m++) begin
                        acc = longint'(sums[m]) * longint'(cfg_target) / total;
                        sums[m] = (acc > ENTRY_MAX) ? ENTRY_MAX : acc[ENTRY_W-1:0];
                     end
                  end
               end
            end
         end
         default: begin
            // built flag is checked before the range
            if (!sums_ready) o.status = ST_UNBUILT;
            else if (int'(r.mask) >= span) o.status = ST_RANGE;
            else o.value = sums[r.mask];
         end
      endcase
      return o;
   endfunction

   function automatic void queue_request(command_type c, logic [IDX_W-1:0] idx,
                                         logic [VAL_W-1:0] v, logic [MASK_W-1:0] m);
      ssvt_req_type r;
      r.cmd   = c;
      r.idx   = idx;
      r.value = v;
      r.mask  = m;
      pending_reqs = {pending_reqs, r};
      queued_total++;
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   // One register write; the local copy follows at the transfer
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [NORM_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_NUM_ITEMS) begin
         cfg_count  = data[NUM_W-1:0];
         sums_ready = 1'b0;
      end else if (idx == CSR_NORMAL_VALUE) begin
         cfg_target = data;
      end
   endtask

   // Every command has one result, so an empty expectation list means idle
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random_phase();
      int               pick;
      int               eff;
      int               span;
      int               n_look;
      int               n_norm;
      int               i;
      int               j;
      int               k;
      logic             zero_all;
      command_type      c;
      logic [NUM_W-1:0] count;
      logic [NORM_W-1:0] target;
      // mostly small tables, a few full-size and out-of-range counts
      pick = $urandom_range(0, 19);
      if (pick == 0) count = 4'd0;
      else if (pick == 1) count = 4'($urandom_range(9, 15));
      else if (pick < 14) count = 4'($urandom_range(1, 4));
      else count = 4'($urandom_range(5, 8));
      pick = $urandom_range(0, 9);
      if (pick < 2) target = '0;
      else if (pick < 4) target = '1;
      else if (pick == 4) target = 16'd1;
      else target = 16'($urandom);
      if ($urandom_range(0, 3) != 0) write_csr(CSR_NORMAL_VALUE, target);
      write_csr(CSR_NUM_ITEMS, {12'd0, count});
      eff  = active_items();
      span = 1 << eff;
      phase_no++;
      @(negedge clock);
      // noise that hits the cleared built flag
      if ($urandom_range(0, 3) == 0)
         queue_request(CMD_LOOKUP, 3'($urandom), 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 5) == 0)
         queue_request(CMD_NORM, 3'($urandom), 16'($urandom), 8'($urandom));
      // load item values, sometimes all zero for the zero-sum case
      zero_all = ($urandom_range(0, 9) == 0);
      for (i = 0; i < ITEM_SLOTS; i++) begin
         if (zero_all ? (i < eff) : ($urandom_range(0, 2) == 0))
            queue_request(CMD_WRITE, 3'(i), zero_all ? 16'd0 : pick_value(), 8'($urandom));
      end
      queue_request(CMD_BUILD, 3'($urandom), 16'($urandom), 8'($urandom));
      n_norm = (eff > 5) ? $urandom_range(0, 1) : $urandom_range(0, 2);
      for (j = 0; j <= n_norm; j++) begin
         n_look = $urandom_range(10, 30);
         for (k = 0; k < n_look; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               c = command_type'($urandom_range(0, 3));
               if (eff > 5 && c == CMD_NORM) c = CMD_LOOKUP;
               queue_request(c, 3'($urandom), pick_value(), 8'($urandom));
            end else if (pick < 3) begin
               queue_request(CMD_LOOKUP, 3'($urandom), 16'($urandom), 8'($urandom));
            end else begin
               queue_request(CMD_LOOKUP, 3'($urandom), 16'($urandom),
                             8'($urandom_range(0, span - 1)));
            end
         end
         if (j < n_norm) queue_request(CMD_NORM, 3'($urandom), 16'($urandom), 8'($urandom));
      end
      wait_drained();
   endtask

   // Request driver: bursts of random length separated by random gaps
   always @(posedge clock) begin : req_driver
      logic         accepted;
      ssvt_rsp_type want_next;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= CMD_WRITE;
      end else begin
         accepted = req_tvalid && req_tready;
         if (accepted) begin
            want_next     = predict_response(pending_reqs.pop_front());
            expected_rsps = {expected_rsps, want_next};
         end
         if (!req_tvalid || accepted) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {5'd0, pending_reqs[0].mask, pending_reqs[0].value,
                              pending_reqs[0].idx};
               req_tuser  <= pending_reqs[0].cmd;
               if (burst_left > 1) burst_left--;
               else begin
                  burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 12);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver stall pattern
   always @(posedge clock) begin : rsp_monitor
      ssvt_rsp_type want;
      logic         rx_ok;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $error("unexpected result transfer: bundle_value %0d status %0d",
                      rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_tdata !== {4'd0, want.value}) begin
                  $error("bundle_value mismatch: expected %0d, actual %0d",
                         want.value, rsp_tdata);
                  error_count++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d", want.status, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(16, 128);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            0:       rx_ok = 1'b1;
            1:       rx_ok = 1'($urandom_range(0, 1));
            2:       rx_ok = (rx_left % 4) == 0;
            default: rx_ok = ($urandom_range(0, 7) != 0);
         endcase
         rsp_tready <= rx_ok && !rsp_hold;
      end
   end

   // Long receiver hold-off so the block backs up onto its input
   initial begin : rsp_holdoff
      wait (phase_no == 3);
      repeat (12) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (400) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: 8 items, normalization off
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'h00);     // lookup before build
      queue_request(CMD_NORM, 3'd0, 16'd0, 8'h00);       // target zero: no effect
      queue_request(CMD_WRITE, 3'd0, 16'hFFFF, 8'h00);
      queue_request(CMD_WRITE, 3'd1, 16'h0001, 8'h00);
      queue_request(CMD_WRITE, 3'd2, 16'h8000, 8'h00);
      queue_request(CMD_WRITE, 3'd3, 16'h5555, 8'h00);
      queue_request(CMD_WRITE, 3'd4, 16'hAAAA, 8'h00);
      queue_request(CMD_WRITE, 3'd5, 16'h0000, 8'h00);
      queue_request(CMD_WRITE, 3'd6, 16'h1234, 8'h00);
      queue_request(CMD_WRITE, 3'd7, 16'hFFFF, 8'h00);
      queue_request(CMD_BUILD, 3'd0, 16'd0, 8'h00);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'hFF);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'h00);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'h55);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'hAA);
      // item rewritten after build: old entry stays until the next build
      queue_request(CMD_WRITE, 3'd0, 16'h0000, 8'h00);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'h01);
      wait_drained();

      // Full-scale normalization on the full table
      write_csr(CSR_NORMAL_VALUE, 16'hFFFF);
      @(negedge clock);
      queue_request(CMD_NORM, 3'd0, 16'd0, 8'h00);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'hFF);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'h0F);
      wait_drained();

      // Count of zero acts as one item; the write also drops the table
      write_csr(CSR_NUM_ITEMS, 16'd0);
      @(negedge clock);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'h01);
      queue_request(CMD_NORM, 3'd0, 16'd0, 8'h00);
      queue_request(CMD_BUILD, 3'd0, 16'd0, 8'h00);
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'h02);     // out of range
      queue_request(CMD_LOOKUP, 3'd0, 16'd0, 8'hFF);
      // zero full-set sum on normalize
      queue_request(CMD_WRITE, 3'd0, 16'h0000, 8'h00);
      queue_request(CMD_BUILD, 3'd0, 16'd0, 8'h00);
      queue_request(CMD_NORM, 3'd0, 16'd0, 8'h00);
      wait_drained();

      while (queued_total < ITEM_TARGET) run_random_phase();

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
